// ----- sv/dllm_pkg.sv -----
`default_nettype none

package dllm_pkg;

	// default pool size
	localparam int NODES_DEF = 64;

	// fixed field widths
	localparam int OP_W  = 4;
	localparam int IDX_W = 6;
	localparam int ST_W  = 2;
	localparam int LEN_W = 7;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD_TAIL   = 4'd0,
		OP_ADD_HEAD   = 4'd1,
		OP_INS_AFTER  = 4'd2,
		OP_INS_BEFORE = 4'd3,
		OP_REMOVE     = 4'd4,
		OP_RM_TAIL    = 4'd5,
		OP_RM_HEAD    = 4'd6,
		OP_HEAD       = 4'd7,
		OP_TAIL       = 4'd8,
		OP_NEXT       = 4'd9,
		OP_PREV       = 4'd10,
		OP_QUERY      = 4'd11
	} op_t;

	// status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK  = 2'd0,
		ST_ON  = 2'd1,
		ST_OFF = 2'd2
	} st_t;

	// request payload
	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [IDX_W-1:0] existing_node;
		logic [IDX_W-1:0] new_node;
	} req_t;

	// result payload
	typedef struct packed {
		logic [IDX_W-1:0] result_node;
		logic             result_valid;
		logic [ST_W-1:0]  status;
		logic [LEN_W-1:0] list_length;
		logic             list_empty;
		logic             node_linked;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr_step;
		logic rd_nw;
		logic chk;
		logic chk2;
		logic wr1;
		logic wr2;
		logic unlink;
		logic out_load;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic need_nw;
		logic do_link;
		logic do_unlink;
		logic nw_ok;
	} stat_t;

endpackage

`default_nettype wire

// ----- sv/dllm_ctrl.sv -----
`default_nettype none

module dllm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	input  wire dllm_pkg::stat_t stat,
	output dllm_pkg::ctl_t      ctl
);

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_CHK  = 8'b0000_0100,
		S_CHK2 = 8'b0000_1000,
		S_WR1  = 8'b0001_0000,
		S_WR2  = 8'b0010_0000,
		S_UNL  = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_CLR: begin
				ctl.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				ctl.chk = 1'b1;
				if (stat.need_nw) begin
					ctl.rd_nw = 1'b1;
					state_d   = S_CHK2;
				end else if (stat.do_link) begin
					state_d = S_WR1;
				end else if (stat.do_unlink) begin
					state_d = S_UNL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_CHK2: begin
				ctl.chk2 = 1'b1;
				state_d  = stat.nw_ok ? S_WR1 : S_FIN;
			end
			S_WR1: begin
				ctl.wr1 = 1'b1;
				state_d = S_WR2;
			end
			S_WR2: begin
				ctl.wr2 = 1'b1;
				state_d = S_FIN;
			end
			S_UNL: begin
				ctl.unlink = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !(rsp_valid_q && rsp_stall))
		else $error("result overwritten while stalled");

	// link writes always come as a pair
	a_link_pair: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr1 |=> ctl.wr2)
		else $error("link write not completed");

endmodule

`default_nettype wire

// ----- sv/dllm_dp.sv -----
`default_nettype none

module dllm_dp #(
	parameter int NODES = dllm_pkg::NODES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dllm_pkg::req_t cmd,
	input  wire dllm_pkg::ctl_t ctl,
	output dllm_pkg::stat_t     stat,
	output dllm_pkg::rsp_t      rsp
);

	localparam int IW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam logic [LW-1:0] SENT = LW'(NODES);

	// captured request
	logic [dllm_pkg::OP_W-1:0]  op_q;
	logic [dllm_pkg::IDX_W-1:0] ex_q;
	logic [dllm_pkg::IDX_W-1:0] nw_q;

	// link and flag memories, sentinel links kept in head_q and tail_q
	logic [LW-1:0] next_mem [NODES];
	logic [LW-1:0] prev_mem [NODES];
	logic          flag_mem [NODES];
	logic [LW-1:0] nx_rd_q, pv_rd_q;
	logic          fl_rd_q;

	logic [LW-1:0] head_q, tail_q;
	logic [LW-1:0] count_q;
	logic [IW-1:0] clr_q;

	// operands of the pending link or unlink
	logic [LW-1:0] a_q, b_q, n_q;
	logic [dllm_pkg::ST_W-1:0] st_q;
	logic [LW-1:0] res_q;
	logic          lex_q;
	dllm_pkg::rsp_t rsp_q;

	// decode signals
	logic          ex_pool, ex_on, nw_pool;
	logic [LW-1:0] ex_l, nw_l, rm_t, rd_node;
	logic [dllm_pkg::ST_W-1:0] c_st, c2_st;
	logic [LW-1:0] c_res, c_a, c_b, c_n;
	logic          c_need_nw, c_link, c_unlink, c_lex;

	// memory port signals
	logic          fl_we, fl_wd, fl_re;
	logic [IW-1:0] fl_wa, fl_ra;
	logic          nx_we, pv_we;
	logic [IW-1:0] nx_wa, pv_wa;
	logic [LW-1:0] nx_wd, pv_wd;
	logic          res_ok;

	assign ex_pool = (32'(ex_q) < NODES);
	assign nw_pool = (32'(nw_q) < NODES);
	assign ex_on   = ex_pool && fl_rd_q;
	assign ex_l    = LW'(ex_q);
	assign nw_l    = LW'(nw_q);
	assign rm_t    = (op_q == dllm_pkg::OP_RM_TAIL) ? tail_q : head_q;

	// first check, on the flag and links read at accept
	always_comb begin
		c_st      = dllm_pkg::ST_OK;
		c_res     = SENT;
		c_a       = a_q;
		c_b       = b_q;
		c_n       = n_q;
		c_need_nw = 1'b0;
		c_link    = 1'b0;
		c_unlink  = 1'b0;
		unique case (op_q)
			dllm_pkg::OP_ADD_TAIL, dllm_pkg::OP_ADD_HEAD: begin
				if (!ex_pool) begin
					c_st = dllm_pkg::ST_OFF;
				end else if (fl_rd_q) begin
					c_st = dllm_pkg::ST_ON;
				end else begin
					c_link = 1'b1;
				end
				c_a = (op_q == dllm_pkg::OP_ADD_TAIL) ? tail_q : SENT;
				c_b = (op_q == dllm_pkg::OP_ADD_TAIL) ? SENT : head_q;
				c_n = ex_l;
			end
			dllm_pkg::OP_INS_AFTER, dllm_pkg::OP_INS_BEFORE: begin
				if (!ex_on) begin
					c_st = dllm_pkg::ST_OFF;
				end else begin
					c_need_nw = 1'b1;
				end
				c_a = (op_q == dllm_pkg::OP_INS_AFTER) ? ex_l : pv_rd_q;
				c_b = (op_q == dllm_pkg::OP_INS_AFTER) ? nx_rd_q : ex_l;
				c_n = nw_l;
			end
			dllm_pkg::OP_REMOVE: begin
				if (!ex_on) begin
					c_st = dllm_pkg::ST_OFF;
				end else begin
					c_unlink = 1'b1;
				end
				c_a = pv_rd_q;
				c_b = nx_rd_q;
				c_n = ex_l;
			end
			dllm_pkg::OP_RM_TAIL, dllm_pkg::OP_RM_HEAD: begin
				if (rm_t != SENT) begin
					c_res    = rm_t;
					c_unlink = 1'b1;
				end
				c_a = pv_rd_q;
				c_b = nx_rd_q;
				c_n = rm_t;
			end
			dllm_pkg::OP_HEAD: begin
				c_res = head_q;
			end
			dllm_pkg::OP_TAIL: begin
				c_res = tail_q;
			end
			dllm_pkg::OP_NEXT, dllm_pkg::OP_PREV: begin
				if (!ex_on) begin
					c_st = dllm_pkg::ST_OFF;
				end else begin
					c_res = (op_q == dllm_pkg::OP_NEXT) ? nx_rd_q : pv_rd_q;
				end
			end
			default: begin
				c_res = SENT;
			end
		endcase
	end

	// on-list flag of existing_node once the operation is done
	always_comb begin
		if (c_link && (op_q == dllm_pkg::OP_ADD_TAIL || op_q == dllm_pkg::OP_ADD_HEAD)) begin
			c_lex = 1'b1;
		end else if (c_unlink && (c_n == ex_l)) begin
			c_lex = 1'b0;
		end else begin
			c_lex = ex_on;
		end
	end

	// second check, new_node of an insert
	always_comb begin
		if (!nw_pool) begin
			c2_st = dllm_pkg::ST_OFF;
		end else if (fl_rd_q) begin
			c2_st = dllm_pkg::ST_ON;
		end else begin
			c2_st = dllm_pkg::ST_OK;
		end
	end

	assign stat.clr_last  = (clr_q == IW'(NODES - 1));
	assign stat.need_nw   = c_need_nw;
	assign stat.do_link   = c_link;
	assign stat.do_unlink = c_unlink;
	assign stat.nw_ok     = nw_pool && !fl_rd_q;

	// capture request and latch check results
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q <= cmd.opcode;
			ex_q <= cmd.existing_node;
			nw_q <= cmd.new_node;
		end
		if (ctl.chk) begin
			st_q  <= c_st;
			res_q <= c_res;
			a_q   <= c_a;
			b_q   <= c_b;
			n_q   <= c_n;
			lex_q <= c_lex;
		end else if (ctl.chk2) begin
			st_q <= c2_st;
		end
	end

	// flag memory: clear pass, set on link, clear on unlink
	assign fl_we = ctl.clr_step || ctl.wr1 || ctl.unlink;
	assign fl_wa = ctl.clr_step ? clr_q : IW'(n_q);
	assign fl_wd = ctl.wr1;
	assign fl_re = ctl.load || ctl.rd_nw;
	assign fl_ra = ctl.rd_nw ? IW'(nw_q) : IW'(cmd.existing_node);

	always_ff @(posedge clk) begin
		if (fl_we) begin
			flag_mem[fl_wa] <= fl_wd;
		end
		if (fl_re) begin
			fl_rd_q <= flag_mem[fl_ra];
		end
	end

	// link memories: new node links first, then the neighbours
	assign nx_we = ctl.wr1 || ((ctl.wr2 || ctl.unlink) && (a_q != SENT));
	assign nx_wa = ctl.wr1 ? IW'(n_q) : IW'(a_q);
	assign nx_wd = ctl.wr2 ? n_q : b_q;
	assign pv_we = ctl.wr1 || ((ctl.wr2 || ctl.unlink) && (b_q != SENT));
	assign pv_wa = ctl.wr1 ? IW'(n_q) : IW'(b_q);
	assign pv_wd = ctl.wr2 ? n_q : a_q;

	// remove-end operations read the links of the end node
	always_comb begin
		if (cmd.opcode == dllm_pkg::OP_RM_TAIL) begin
			rd_node = tail_q;
		end else if (cmd.opcode == dllm_pkg::OP_RM_HEAD) begin
			rd_node = head_q;
		end else begin
			rd_node = LW'(cmd.existing_node);
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (ctl.load) begin
			nx_rd_q <= next_mem[IW'(rd_node)];
		end
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (ctl.load) begin
			pv_rd_q <= prev_mem[IW'(rd_node)];
		end
	end

	// sentinel links, length and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= SENT;
			tail_q  <= SENT;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (ctl.clr_step) begin
				clr_q <= clr_q + IW'(1);
			end
			if (ctl.wr2) begin
				if (a_q == SENT) begin
					head_q <= n_q;
				end
				if (b_q == SENT) begin
					tail_q <= n_q;
				end
				count_q <= count_q + LW'(1);
			end else if (ctl.unlink) begin
				if (a_q == SENT) begin
					head_q <= b_q;
				end
				if (b_q == SENT) begin
					tail_q <= a_q;
				end
				count_q <= count_q - LW'(1);
			end
		end
	end

	// result register
	assign res_ok = (res_q != SENT);

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q.result_node  <= res_ok ? dllm_pkg::IDX_W'(res_q) : '0;
			rsp_q.result_valid <= res_ok;
			rsp_q.status       <= st_q;
			rsp_q.list_length  <= dllm_pkg::LEN_W'(count_q);
			rsp_q.list_empty   <= (count_q == '0);
			rsp_q.node_linked  <= lex_q;
		end
	end

	assign rsp = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= NODES)
		else $error("list length beyond pool size");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == '0) == (head_q == SENT)) && ((head_q == SENT) == (tail_q == SENT)))
		else $error("sentinel links disagree with length");

	a_unlink_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.unlink |-> (count_q != '0))
		else $error("unlink on empty list");

endmodule

`default_nettype wire

// ----- sv/doubly_linked_list_manager.sv -----
// Path from accept to result: get, query and requests refused on the first check go from
// the check to the finish state; remove and remove-end add an unlink state, an insert refused
// on its new node a second check, an add the two link writes, an insert the second check and both writes.
// One request at a time: the next is taken the cycle after the result is registered, and a
// result waits in the finish state while an earlier result still stalls output.
// Reset: list empty, then a clearing pass over all NODES on-list flags, no accept.
`default_nettype none

module doubly_linked_list_manager #(
	parameter int NODES = dllm_pkg::NODES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire dllm_pkg::req_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dllm_pkg::rsp_t      rsp
);

	dllm_pkg::ctl_t  ctl;
	dllm_pkg::stat_t stat;

	// sequencer
	dllm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// link memories and result
	dllm_dp #(
		.NODES (NODES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ----- tb/tb_doubly_linked_list_manager.sv -----
module tb_doubly_linked_list_manager;

	localparam int NODES = dllm_pkg::NODES_DEF;
	localparam int SENT  = NODES;
	// two copies of the list: one follows accepted requests, one plans stimulus
	localparam int LIVE  = 0;
	localparam int PLAN  = 1;
	localparam int RANDOM_ITEMS = 400;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_LONG
	} stall_mode_t;

	typedef enum int {
		SEQ_FILL,
		SEQ_DRAIN,
		SEQ_MIXED,
		SEQ_NOISE
	} seq_kind_t;

	// a request waiting to be driven, optionally held until the block drains
	typedef struct packed {
		logic           hold;
		dllm_pkg::req_t req;
	} cmd_plan_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	dllm_pkg::req_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dllm_pkg::rsp_t rsp;

	// list shadow state
	int nxt_lnk [0:1][0:NODES];
	int prv_lnk [0:1][0:NODES];
	bit on_lst  [0:1][0:NODES-1];
	int lst_len [0:1];

	cmd_plan_t      cmd_plan_q [$];
	dllm_pkg::rsp_t rsp_due_q [$];
	dllm_pkg::rsp_t rsp_want;
	int        mismatches = 0;
	int        planned    = 0;
	bit        hold_next  = 1'b0;
	int        burst_left = 0;
	int        gap_left   = 0;
	int        stall_cyc  = 0;
	stall_mode_t stall_mode = STALL_NONE;

	doubly_linked_list_manager #(
		.NODES(NODES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock and reset
	always #1 clk = ~clk;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// list model
	function automatic void clear_list(int c);
		for (int i = 0; i <= NODES; i++) begin
			nxt_lnk[c][i] = 0;
			prv_lnk[c][i] = 0;
		end
		for (int i = 0; i < NODES; i++)
			on_lst[c][i] = 1'b0;
		nxt_lnk[c][SENT] = SENT;
		prv_lnk[c][SENT] = SENT;
		lst_len[c] = 0;
	endfunction

	function automatic void link_after(int c, int a, int n);
		int b;
		b = nxt_lnk[c][a];
		nxt_lnk[c][n] = b;
		prv_lnk[c][n] = a;
		prv_lnk[c][b] = n;
		nxt_lnk[c][a] = n;
		on_lst[c][n] = 1'b1;
		lst_len[c]++;
	endfunction

	function automatic void unlink(int c, int n);
		int p;
		int q;
		p = prv_lnk[c][n];
		q = nxt_lnk[c][n];
		nxt_lnk[c][p] = q;
		prv_lnk[c][q] = p;
		nxt_lnk[c][n] = 0;
		prv_lnk[c][n] = 0;
		on_lst[c][n] = 1'b0;
		lst_len[c]--;
	endfunction

	// applies one request to a list copy and returns the result it reports
	function automatic dllm_pkg::rsp_t apply_list_op(int c, dllm_pkg::req_t r);
		dllm_pkg::rsp_t o;
		dllm_pkg::st_t  st;
		int   ex;
		int   nw;
		int   res;
		int   t;
		int   anc;
		ex  = r.existing_node;
		nw  = r.new_node;
		st  = dllm_pkg::ST_OK;
		res = SENT;
		case (r.opcode)
			dllm_pkg::OP_ADD_TAIL, dllm_pkg::OP_ADD_HEAD: begin
				anc = (r.opcode == dllm_pkg::OP_ADD_TAIL) ? prv_lnk[c][SENT] : SENT;
				if (on_lst[c][ex])
					st = dllm_pkg::ST_ON;
				else
					link_after(c, anc, ex);
			end
			dllm_pkg::OP_INS_AFTER, dllm_pkg::OP_INS_BEFORE: begin
				// anchor is checked before the new node
				anc = (r.opcode == dllm_pkg::OP_INS_AFTER) ? ex : prv_lnk[c][ex];
				if (!on_lst[c][ex])
					st = dllm_pkg::ST_OFF;
				else if (on_lst[c][nw])
					st = dllm_pkg::ST_ON;
				else
					link_after(c, anc, nw);
			end
			dllm_pkg::OP_REMOVE: begin
				if (!on_lst[c][ex])
					st = dllm_pkg::ST_OFF;
				else
					unlink(c, ex);
			end
			dllm_pkg::OP_RM_TAIL, dllm_pkg::OP_RM_HEAD: begin
				t = (r.opcode == dllm_pkg::OP_RM_TAIL) ? prv_lnk[c][SENT] : nxt_lnk[c][SENT];
				if (t != SENT) begin
					res = t;
					unlink(c, t);
				end
			end
			dllm_pkg::OP_HEAD: res = nxt_lnk[c][SENT];
			dllm_pkg::OP_TAIL: res = prv_lnk[c][SENT];
			dllm_pkg::OP_NEXT, dllm_pkg::OP_PREV: begin
				if (!on_lst[c][ex])
					st = dllm_pkg::ST_OFF;
				else
					res = (r.opcode == dllm_pkg::OP_NEXT) ? nxt_lnk[c][ex] : prv_lnk[c][ex];
			end
			default: ;
		endcase
		// sentinel means no node
		if (res >= NODES) begin
			o.result_node  = '0;
			o.result_valid = 1'b0;
		end else begin
			o.result_node  = dllm_pkg::IDX_W'(res);
			o.result_valid = 1'b1;
		end
		o.status      = st;
		o.list_length = dllm_pkg::LEN_W'(lst_len[c]);
		o.list_empty  = (lst_len[c] == 0);
		o.node_linked = on_lst[c][ex];
		return o;
	endfunction

	// random node that is on, or off, the planned list
	function automatic int pick_node(bit want_on);
		int cand [$];
		for (int i = 0; i < NODES; i++)
			if (on_lst[PLAN][i] == want_on)
				cand.push_back(i);
		if (cand.size() == 0)
			return $urandom_range(0, NODES - 1);
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	task automatic plan_req(input int op, input int ex, input int nw);
		dllm_pkg::req_t r;
		r.opcode        = dllm_pkg::OP_W'(op);
		r.existing_node = dllm_pkg::IDX_W'(ex);
		r.new_node      = dllm_pkg::IDX_W'(nw);
		cmd_plan_q.push_back({hold_next, r});
		void'(apply_list_op(PLAN, r));
		hold_next = 1'b0;
		planned++;
	endtask

	// stimulus
	task automatic build_stimulus();
		int        k;
		int        op;
		seq_kind_t kind;
		bit        first;
		// empty list corner cases
		plan_req(dllm_pkg::OP_QUERY, 0, 0);
		plan_req(dllm_pkg::OP_HEAD, 0, 0);
		plan_req(dllm_pkg::OP_TAIL, 0, 0);
		plan_req(dllm_pkg::OP_RM_TAIL, 0, 0);
		plan_req(dllm_pkg::OP_RM_HEAD, 0, 0);
		plan_req(dllm_pkg::OP_REMOVE, 5, 0);
		plan_req(dllm_pkg::OP_NEXT, 5, 0);
		plan_req(dllm_pkg::OP_PREV, 5, 0);
		plan_req(dllm_pkg::OP_INS_AFTER, 5, 6);
		// build a short list and hit the already-on-list cases
		plan_req(dllm_pkg::OP_ADD_TAIL, 0, 0);
		plan_req(dllm_pkg::OP_ADD_HEAD, 63, 63);
		plan_req(dllm_pkg::OP_ADD_TAIL, 0, 0);
		plan_req(dllm_pkg::OP_INS_AFTER, 5, 0);
		plan_req(dllm_pkg::OP_INS_AFTER, 0, 42);
		plan_req(dllm_pkg::OP_INS_BEFORE, 63, 21);
		plan_req(dllm_pkg::OP_INS_AFTER, 0, 63);
		plan_req(dllm_pkg::OP_INS_BEFORE, 0, 0);
		// gets, walking off either end onto the sentinel, then an unused opcode and removes
		plan_req(dllm_pkg::OP_HEAD, 0, 0);
		plan_req(dllm_pkg::OP_TAIL, 0, 0);
		plan_req(dllm_pkg::OP_NEXT, 42, 0);
		plan_req(dllm_pkg::OP_PREV, 21, 0);
		plan_req(dllm_pkg::OP_NEXT, 63, 0);
		plan_req(dllm_pkg::OP_PREV, 0, 0);
		plan_req(2**dllm_pkg::OP_W - 1, 42, 0);
		plan_req(dllm_pkg::OP_REMOVE, 63, 0);
		plan_req(dllm_pkg::OP_RM_TAIL, 0, 0);
		plan_req(dllm_pkg::OP_RM_HEAD, 0, 0);

		// random sequences, mostly well formed
		first = 1'b1;
		while (planned < RANDOM_ITEMS + 27) begin
			k = $urandom_range(0, 9);
			if (first)
				kind = SEQ_FILL;
			else if (k == 0)
				kind = SEQ_FILL;
			else if (k == 1)
				kind = SEQ_DRAIN;
			else if (k < 7)
				kind = SEQ_MIXED;
			else
				kind = SEQ_NOISE;
			hold_next = first || ($urandom_range(0, 3) == 0);
			first = 1'b0;
			case (kind)
				SEQ_FILL: begin
					while (lst_len[PLAN] < NODES) begin
						k = $urandom_range(0, 9);
						if (k < 6 || lst_len[PLAN] == 0)
							plan_req((k % 2 == 0) ? dllm_pkg::OP_ADD_TAIL : dllm_pkg::OP_ADD_HEAD,
								pick_node(1'b0), $urandom_range(0, NODES - 1));
						else if (k < 8)
							plan_req((k == 6) ? dllm_pkg::OP_INS_AFTER : dllm_pkg::OP_INS_BEFORE,
								pick_node(1'b1), pick_node(1'b0));
						else
							plan_req($urandom_range(dllm_pkg::OP_HEAD, dllm_pkg::OP_QUERY),
								pick_node(1'b1), $urandom_range(0, NODES - 1));
					end
					// full list: every add or insert is refused
					repeat (4)
						plan_req($urandom_range(dllm_pkg::OP_ADD_TAIL, dllm_pkg::OP_INS_BEFORE),
							pick_node(1'b1), pick_node(1'b1));
					plan_req(dllm_pkg::OP_HEAD, 0, 0);
					plan_req(dllm_pkg::OP_TAIL, 0, 0);
				end
				SEQ_DRAIN: begin
					while (lst_len[PLAN] > 0) begin
						k = $urandom_range(0, 9);
						if (k < 3)
							plan_req(dllm_pkg::OP_RM_HEAD, $urandom_range(0, NODES - 1), 0);
						else if (k < 6)
							plan_req(dllm_pkg::OP_RM_TAIL, $urandom_range(0, NODES - 1), 0);
						else if (k < 8)
							plan_req(dllm_pkg::OP_REMOVE, pick_node(1'b1), 0);
						else
							plan_req((k == 8) ? dllm_pkg::OP_NEXT : dllm_pkg::OP_PREV,
								pick_node(1'b1), 0);
					end
					plan_req(dllm_pkg::OP_RM_HEAD, 0, 0);
					plan_req(dllm_pkg::OP_TAIL, 0, 0);
				end
				SEQ_MIXED: begin
					repeat (20) begin
						op = $urandom_range(dllm_pkg::OP_ADD_TAIL, dllm_pkg::OP_QUERY);
						if (op == dllm_pkg::OP_ADD_TAIL || op == dllm_pkg::OP_ADD_HEAD)
							k = pick_node($urandom_range(0, 4) == 0);
						else
							k = pick_node($urandom_range(0, 4) != 0);
						plan_req(op, k, pick_node($urandom_range(0, 4) == 0));
					end
				end
				default: begin
					repeat (10)
						plan_req($urandom_range(0, 2**dllm_pkg::OP_W - 1),
							$urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
				end
			endcase
		end
	endtask

	initial begin
		clear_list(LIVE);
		clear_list(PLAN);
		build_stimulus();
		wait (arst_n === 1'b1);
		while (cmd_plan_q.size() != 0 || cmd_valid || rsp_due_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

	// request driver: bursts with gaps, optional hold until the block drains
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				rsp_due_q.push_back(apply_list_op(LIVE, cmd));
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (cmd_plan_q.size() != 0 &&
						!(cmd_plan_q[0].hold && rsp_due_q.size() != 0)) begin
					cmd       <= cmd_plan_q[0].req;
					cmd_valid <= 1'b1;
					void'(cmd_plan_q.pop_front());
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result monitor and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due_q.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					rsp_want = rsp_due_q.pop_front();
					check_field("result_node", rsp_want.result_node, rsp.result_node);
					check_field("result_valid", rsp_want.result_valid, rsp.result_valid);
					check_field("status", rsp_want.status, rsp.status);
					check_field("list_length", rsp_want.list_length, rsp.list_length);
					check_field("list_empty", rsp_want.list_empty, rsp.list_empty);
					check_field("node_linked", rsp_want.node_linked, rsp.node_linked);
				end
			end
			stall_cyc++;
			if (stall_cyc % 64 == 0)
				stall_mode = stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:     rsp_stall <= 1'b0;
				STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 1) == 1);
				STALL_PERIODIC: rsp_stall <= (stall_cyc % 5 < 2);
				default:        rsp_stall <= (stall_cyc % 9 < 6);
			endcase
		end
	end

endmodule
